// File: rtl/ialu_pkg.sv
// ialu_pkg: opcodes, status codes and the packet type handed between the alu cells
// no dependencies
`default_nettype none
package ialu_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int KIND_W = 4;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] OP_ADD = 4'd0;
  localparam logic [KIND_W-1:0] OP_SUB = 4'd1;
  localparam logic [KIND_W-1:0] OP_DIV = 4'd2;
  localparam logic [KIND_W-1:0] OP_MUL = 4'd3;
  localparam logic [KIND_W-1:0] OP_POW = 4'd4;
  localparam logic [KIND_W-1:0] OP_AND = 4'd5;
  localparam logic [KIND_W-1:0] OP_OR  = 4'd6;
  localparam logic [KIND_W-1:0] OP_XOR = 4'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADOP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

  // control carried alongside the data through the chain
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic                neg;     // negate final result
    logic                done;    // result already settled
    logic [STATUS_W-1:0] status;
  } ctl_t;
endpackage
`default_nettype wire

// File: rtl/integer_alu_with_divide_power.sv
// integer_alu_with_divide_power: top level, entry decode, chain of cells, exit stage
// depends on ialu_pkg and ialu_cell
`default_nettype none
// Signed integer ALU: add, sub, truncating divide, multiply, power, and, or, xor.
// Every request enters a chain of DATA_WIDTH cells plus an entry and an exit
// stage, and one request is taken per cycle unless the output stalls. Each cell
// does one restoring divide bit or one square-and-multiply power step. A stall
// on the output halts the whole chain.
module integer_alu_with_divide_power import ialu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [KIND_W-1:0]            in_kind,
  input  wire logic signed [DATA_WIDTH-1:0] in_first_operand,
  input  wire logic signed [DATA_WIDTH-1:0] in_second_operand,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_result,
  output logic [STATUS_W-1:0]               out_status
);
  localparam int W = DATA_WIDTH;
  localparam int N = W;
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic en;
  ctl_t ctl [N+1];
  logic [W-1:0] acc [N+1];
  logic [W-1:0] rem [N+1];
  logic [W-1:0] opa [N+1];
  logic [W-1:0] opb [N+1];
  logic bov [N+1];

  ctl_t ctl_nxt;
  logic [W-1:0] acc_nxt, rem_nxt, opa_nxt, opb_nxt;
  logic [W-1:0] a, b, ma, mb;
  logic [W-1:0] mprod;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  // entry decode: simple ops finish here, div and pow get set up
  always_comb begin
    a = in_first_operand;
    b = in_second_operand;
    ma = a[W-1] ? -a : a;
    mb = b[W-1] ? -b : b;
    mprod = a * b;
    ctl_nxt.valid = in_valid;
    ctl_nxt.kind = in_kind;
    ctl_nxt.neg = 1'b0;
    ctl_nxt.done = 1'b1;
    ctl_nxt.status = ST_OK;
    acc_nxt = '0;
    rem_nxt = '0;
    opa_nxt = '0;
    opb_nxt = '0;
    unique case (in_kind)
      OP_ADD: acc_nxt = a + b;
      OP_SUB: acc_nxt = a - b;
      OP_MUL: acc_nxt = mprod;
      OP_AND: acc_nxt = a & b;
      OP_OR:  acc_nxt = a | b;
      OP_XOR: acc_nxt = a ^ b;
      OP_DIV: begin
        if (b == '0) ctl_nxt.status = ST_DIV0;
        else if (a == SIGN && b == '1) ctl_nxt.status = ST_OVF;
        else begin
          ctl_nxt.done = 1'b0;
          ctl_nxt.neg = a[W-1] ^ b[W-1];
          opa_nxt = ma;
          opb_nxt = mb;
        end
      end
      OP_POW: begin
        if (b == '0 || a == ONE) acc_nxt = ONE;
        else if (a == '1) acc_nxt = b[0] ? '1 : ONE;
        else if (b[W-1]) begin
          if (a == '0) ctl_nxt.status = ST_OVF;
        end else if (a == '0) acc_nxt = '0;
        else begin
          ctl_nxt.done = 1'b0;
          ctl_nxt.neg = a[W-1] & b[0];
          acc_nxt = ONE;
          rem_nxt = ma;
          opa_nxt = b;
          opb_nxt = (a[W-1] & b[0]) ? SIGN : ~SIGN;
        end
      end
      default: ctl_nxt.status = ST_BADOP;
    endcase
  end

  // entry stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl[0].valid <= 1'b0;
    end else if (en) begin
      ctl[0].valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl[0].kind <= ctl_nxt.kind;
      ctl[0].neg <= ctl_nxt.neg;
      ctl[0].done <= ctl_nxt.done;
      ctl[0].status <= ctl_nxt.status;
      acc[0] <= acc_nxt;
      rem[0] <= rem_nxt;
      opa[0] <= opa_nxt;
      opb[0] <= opb_nxt;
      bov[0] <= (ma > opb_nxt);
    end
  end

  // chain of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    ialu_cell #(.DATA_WIDTH(W), .IDX(i)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(ctl[i]), .acc_i(acc[i]), .rem_i(rem[i]), .opa_i(opa[i]),
      .opb_i(opb[i]), .bov_i(bov[i]),
      .ctl_o(ctl[i+1]), .acc_o(acc[i+1]), .rem_o(rem[i+1]), .opa_o(opa[i+1]),
      .opb_o(opb[i+1]), .bov_o(bov[i+1])
    );
  end

  // exit stage: sign fix and zeroing on error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl[N].valid;
    end
    if (en) begin
      out_status <= ctl[N].status;
      if (ctl[N].status != ST_OK) out_result <= '0;
      else if (ctl[N].neg) out_result <= -acc[N];
      else out_result <= acc[N];
    end
  end

  // errors always come with a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result == '0)
    else $error("error status with nonzero result");

  // held output while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("output changed under stall");

  // input stall only follows a stalled full output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
endmodule
`default_nettype wire

// File: rtl/ialu_cell.sv
// ialu_cell: one stage of the chain; one restoring divide step or one power step
// depends on ialu_pkg
`default_nettype none
module ialu_cell import ialu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire ctl_t                  ctl_i,
  input  wire logic [DATA_WIDTH-1:0] acc_i,   // quotient bits / power result
  input  wire logic [DATA_WIDTH-1:0] rem_i,   // partial remainder / squared base
  input  wire logic [DATA_WIDTH-1:0] opa_i,   // dividend magnitude / exponent
  input  wire logic [DATA_WIDTH-1:0] opb_i,   // divisor magnitude / limit
  input  wire logic                  bov_i,   // squared base beyond limit
  output ctl_t                       ctl_o,
  output logic [DATA_WIDTH-1:0]      acc_o,
  output logic [DATA_WIDTH-1:0]      rem_o,
  output logic [DATA_WIDTH-1:0]      opa_o,
  output logic [DATA_WIDTH-1:0]      opb_o,
  output logic                       bov_o
);
  localparam int W = DATA_WIDTH;
  localparam int BIT = W - 1 - IDX;

  ctl_t ctl_nxt;
  logic [W-1:0] acc_nxt, rem_nxt;
  logic bov_nxt;
  logic [W:0] trial;
  logic [2*W-1:0] prod, sq;
  logic pow_ovf;

  // one quotient bit, or one square-and-multiply step
  always_comb begin
    ctl_nxt = ctl_i;
    acc_nxt = acc_i;
    rem_nxt = rem_i;
    bov_nxt = bov_i;
    trial = {rem_i, opa_i[BIT]} - {1'b0, opb_i};
    prod = {{W{1'b0}}, acc_i} * {{W{1'b0}}, rem_i};
    sq = {{W{1'b0}}, rem_i} * {{W{1'b0}}, rem_i};
    pow_ovf = 1'b0;
    if (ctl_i.valid && !ctl_i.done && ctl_i.kind == OP_DIV) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        acc_nxt = {acc_i[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_i[W-2:0], opa_i[BIT]};
        acc_nxt = {acc_i[W-2:0], 1'b0};
      end
    end else if (ctl_i.valid && !ctl_i.done && ctl_i.kind == OP_POW) begin
      // exponent bit IDX, lsb first; base powers squared each step
      if (IDX < W && opa_i[IDX]) begin
        if (bov_i || prod[2*W-1:W] != '0 || prod[W-1:0] > opb_i) pow_ovf = 1'b1;
        acc_nxt = prod[W-1:0];
      end
      if (opa_i >> (IDX + 1) != '0) begin
        if (bov_i) pow_ovf = 1'b1;
      end
      rem_nxt = sq[W-1:0];
      bov_nxt = bov_i || sq[2*W-1:W] != '0 || sq[W-1:0] > opb_i;
      if (pow_ovf) begin
        ctl_nxt.done = 1'b1;
        ctl_nxt.status = ST_OVF;
      end
    end
  end

  // hand on to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl_o.kind <= ctl_nxt.kind;
      ctl_o.neg <= ctl_nxt.neg;
      ctl_o.done <= ctl_nxt.done;
      ctl_o.status <= ctl_nxt.status;
      acc_o <= acc_nxt;
      rem_o <= rem_nxt;
      opa_o <= opa_i;
      opb_o <= opb_i;
      bov_o <= bov_nxt;
    end
  end
endmodule
`default_nettype wire
